// File: rtl/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared types, register indexes and helpers for the fall detection block.
// ----------------------------------------------------------------------------
package fdf_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned AngleW   = 13;
  localparam int unsigned MagW     = 13;
  localparam int unsigned LimitW   = 12;
  localparam int unsigned AccelW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned WindowW  = 16;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_IMPACT    = 2'd1,
    PH_CONFIRMED = 2'd2,
    PH_CRITICAL  = 2'd3
  } fdf_phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHOCK_LEVEL        = 3'd0,
    REG_STABLE_WINDOW_MS   = 3'd1,
    REG_LAY_ANGLE          = 3'd2,
    REG_CRITICAL_WINDOW_MS = 3'd3,
    REG_STAND_ANGLE        = 3'd4,
    REG_MOVEMENT_THRESHOLD = 3'd5
  } fdf_reg_t;

  localparam logic [AccelW-1:0]  ShockLevelRst        = 16'd20000;
  localparam logic [WindowW-1:0] StableWindowRst      = 16'd2000;
  localparam logic [LimitW-1:0]  LayAngleRst          = 12'd320;
  localparam logic [WindowW-1:0] CriticalWindowRst    = 16'd10000;
  localparam logic [LimitW-1:0]  StandAngleRst        = 12'd480;
  localparam logic [AccelW-1:0]  MovementThresholdRst = 16'd12000;

  typedef struct packed {
    logic [AccelW-1:0]  shock_level;
    logic [WindowW-1:0] stable_window_ms;
    logic [LimitW-1:0]  lay_angle;
    logic [WindowW-1:0] critical_window_ms;
    logic [LimitW-1:0]  stand_angle;
    logic [AccelW-1:0]  movement_threshold;
  } fdf_cfg_t;

  typedef struct packed {
    fdf_phase_t phase;
    logic       mark_load;
  } fdf_step_t;

  // Magnitude of a two's complement angle; the most negative code gives 4096.
  function automatic logic [MagW-1:0] angle_mag(input logic signed [AngleW-1:0] a);
    logic [MagW-1:0] neg;
    neg = MagW'(-a);
    return a[AngleW-1] ? neg : MagW'(a);
  endfunction

endpackage

// File: rtl/fall_detect_fsm_top.sv
// ----------------------------------------------------------------------------
// fall_detect_fsm_top
// Fall detection phase tracker: one phase beat out for each sample beat in.
// ----------------------------------------------------------------------------
// Each accepted sample gives one fall_phase beat, in the cycle after acceptance;
// a sample can be taken every cycle. The phase update is a single pass of
// compares and one 32-bit subtract between the sample port and the result
// register; a held result stalls the input only while out_ready stays low.
// Configuration writes land at once and must be made while idle.
// ----------------------------------------------------------------------------
module fall_detect_fsm_top
  import fdf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic        [CfgIdxW-1:0] cfg_index,
  input  logic        [CfgDataW-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [AngleW-1:0]  pitch_angle,
  input  logic signed [AngleW-1:0]  roll_angle,
  input  logic        [AccelW-1:0]  accel_magnitude,
  input  logic        [TimeW-1:0]   timestamp_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic        [1:0]         fall_phase
);

  fdf_cfg_t         cfg;
  fdf_phase_t       phase;
  logic [TimeW-1:0] mark_time;
  fdf_step_t        step;
  logic             in_beat;

  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shock_level        <= ShockLevelRst;
      cfg.stable_window_ms   <= StableWindowRst;
      cfg.lay_angle          <= LayAngleRst;
      cfg.critical_window_ms <= CriticalWindowRst;
      cfg.stand_angle        <= StandAngleRst;
      cfg.movement_threshold <= MovementThresholdRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHOCK_LEVEL:        cfg.shock_level        <= cfg_data;
        REG_STABLE_WINDOW_MS:   cfg.stable_window_ms   <= cfg_data;
        REG_LAY_ANGLE:          cfg.lay_angle          <= cfg_data[LimitW-1:0];
        REG_CRITICAL_WINDOW_MS: cfg.critical_window_ms <= cfg_data;
        REG_STAND_ANGLE:        cfg.stand_angle        <= cfg_data[LimitW-1:0];
        REG_MOVEMENT_THRESHOLD: cfg.movement_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  fdf_phase_logic u_phase_logic (
    .cfg             (cfg),
    .phase           (phase),
    .mark_time       (mark_time),
    .pitch_angle     (pitch_angle),
    .roll_angle      (roll_angle),
    .accel_magnitude (accel_magnitude),
    .timestamp_ms    (timestamp_ms),
    .step            (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      mark_time <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_beat) begin
        phase <= step.phase;
        if (step.mark_load) mark_time <= timestamp_ms;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) fall_phase <= step.phase;
  end

endmodule

// File: rtl/fdf_phase_logic.sv
// ----------------------------------------------------------------------------
// fdf_phase_logic
// Next phase and time mark load for one sample, from the current phase.
// ----------------------------------------------------------------------------
module fdf_phase_logic
  import fdf_pkg::*;
(
  input  fdf_cfg_t                   cfg,
  input  fdf_phase_t                 phase,
  input  logic        [TimeW-1:0]    mark_time,
  input  logic signed [AngleW-1:0]   pitch_angle,
  input  logic signed [AngleW-1:0]   roll_angle,
  input  logic        [AccelW-1:0]   accel_magnitude,
  input  logic        [TimeW-1:0]    timestamp_ms,
  output fdf_step_t                  step
);

  logic [MagW-1:0]  pmag;
  logic [MagW-1:0]  rmag;
  logic [TimeW-1:0] elapsed;
  logic             impact_hit;
  logic             stable_done;
  logic             lying;
  logic             standing;
  logic             moving;
  logic             critical_done;
  fdf_phase_t       phase_next;

  assign pmag          = angle_mag(pitch_angle);
  assign rmag          = angle_mag(roll_angle);
  assign elapsed       = timestamp_ms - mark_time;
  assign impact_hit    = accel_magnitude > cfg.shock_level;
  assign stable_done   = elapsed > TimeW'(cfg.stable_window_ms);
  assign critical_done = elapsed > TimeW'(cfg.critical_window_ms);
  assign lying         = (pmag < MagW'(cfg.lay_angle)) || (rmag < MagW'(cfg.lay_angle));
  assign standing      = (pmag > MagW'(cfg.stand_angle)) || (rmag > MagW'(cfg.stand_angle));
  assign moving        = accel_magnitude > cfg.movement_threshold;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (impact_hit) phase_next = PH_IMPACT;
      end
      PH_IMPACT: begin
        if (stable_done) phase_next = lying ? PH_CONFIRMED : PH_IDLE;
      end
      PH_CONFIRMED: begin
        priority if (standing)      phase_next = PH_IDLE;
        else if (moving)            phase_next = PH_IDLE;
        else if (critical_done)     phase_next = PH_CRITICAL;
        else                        phase_next = PH_CONFIRMED;
      end
      PH_CRITICAL: begin
        phase_next = PH_CRITICAL;
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_comb begin
    step.phase     = phase_next;
    step.mark_load = 1'b0;
    unique case (phase)
      PH_IDLE:      step.mark_load = impact_hit;
      PH_IMPACT:    step.mark_load = stable_done && lying;
      PH_CONFIRMED: step.mark_load = 1'b0;
      PH_CRITICAL:  step.mark_load = 1'b0;
      default:      step.mark_load = 1'b0;
    endcase
  end

endmodule

// File: rtl/fdf_checker.sv
// ----------------------------------------------------------------------------
// fdf_checker
// Port-level checks for the fall detection block, bound to the top level.
// ----------------------------------------------------------------------------
module fdf_checker
  import fdf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] fall_phase
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fall_phase))
    else $error("stalled result beat changed");

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted sample gave no result beat");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_critical_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fall_phase == PH_CRITICAL) |=>
      !out_valid || (fall_phase == PH_CRITICAL))
    else $error("critical phase left without reset");

endmodule

bind fall_detect_fsm_top fdf_checker u_fdf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .fall_phase (fall_phase)
);

// File: tb/sv/fall_detect_fsm_top_tb.sv
// ----------------------------------------------------------------------------
// fall_detect_fsm_top_tb
// Self-checking bench for the fall detection phase tracker.
// ----------------------------------------------------------------------------
// A directed table covers threshold edges, the posture checks, timestamp wrap
// and backward jumps, and the angle extremes. Episodes of random samples
// follow under six register settings with varied handshake idling. Each
// accepted sample is run through a local model of the phase machine, and
// every fall_phase beat is compared with the oldest pending phase. The
// critical phase holds until reset, so it is only entered at the end.
// ----------------------------------------------------------------------------
module fall_detect_fsm_top_tb;
  import fdf_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int SetItems   = 310;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct {
    logic signed [AngleW-1:0] pitch;
    logic signed [AngleW-1:0] roll;
    logic [AccelW-1:0]        accel;
    logic [TimeW-1:0]         ts;
    bit                       fixed;
    fdf_phase_t               want;
  } sample_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic        [CfgIdxW-1:0]  cfg_index;
  logic        [CfgDataW-1:0] cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [AngleW-1:0]   pitch_angle;
  logic signed [AngleW-1:0]   roll_angle;
  logic        [AccelW-1:0]   accel_magnitude;
  logic        [TimeW-1:0]    timestamp_ms;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic        [1:0]          fall_phase;

  fdf_cfg_t    cfg_copy;
  fdf_phase_t  track_phase;
  logic [31:0] track_mark;
  logic [31:0] now_ms;
  fdf_phase_t  phase_due [$];
  fdf_phase_t  due_phase;
  int          err_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          allow_critical = 1'b0;

  sample_t probe_rows [19] = '{
    '{0,     0,     0,     32'd0,          1'b1, PH_IDLE},
    '{0,     0,     20000, 32'd100,        1'b1, PH_IDLE},
    '{0,     0,     20001, 32'd200,        1'b1, PH_IMPACT},
    '{0,     0,     0,     32'd2200,       1'b0, PH_IDLE},
    '{2880,  -2880, 65535, 32'd2201,       1'b1, PH_IDLE},
    '{0,     0,     65535, 32'd3000,       1'b0, PH_IDLE},
    '{-4096, 319,   0,     32'd5001,       1'b1, PH_CONFIRMED},
    '{480,   -480,  12000, 32'd15001,      1'b0, PH_IDLE},
    '{0,     0,     12001, 32'd15002,      1'b0, PH_IDLE},
    '{0,     0,     30000, 32'd20000,      1'b0, PH_IDLE},
    '{320,   320,   0,     32'd22001,      1'b0, PH_IDLE},
    '{0,     0,     30000, 32'd4294967000, 1'b0, PH_IDLE},
    '{0,     0,     0,     32'd1704,       1'b0, PH_IDLE},
    '{-1,    4095,  0,     32'd1705,       1'b0, PH_IDLE},
    '{-4096, 0,     65535, 32'd1706,       1'b1, PH_IDLE},
    '{0,     0,     20001, 32'd5000,       1'b0, PH_IDLE},
    '{0,     0,     0,     32'd4000,       1'b1, PH_CONFIRMED},
    '{0,     481,   0,     32'd4001,       1'b0, PH_IDLE},
    '{100,   200,   100,   32'd4002,       1'b0, PH_IDLE}
  };

  fdf_cfg_t phase_settings [6] = '{
    '{16'd20000, 16'd2000,  12'd320,  16'd10000, 12'd480,  16'd12000},
    '{16'd0,     16'd0,     12'd0,    16'd0,     12'd0,    16'd0},
    '{16'd1000,  16'd50,    12'd2880, 16'd300,   12'd2880, 16'd500},
    '{16'd65535, 16'd65535, 12'd4095, 16'd65535, 12'd4095, 16'd65535},
    '{16'd30000, 16'd100,   12'd1000, 16'd1000,  12'd1500, 16'd40000},
    '{16'd15000, 16'd500,   12'd600,  16'd2000,  12'd200,  16'd8000}
  };

  fall_detect_fsm_top DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pitch_angle     (pitch_angle),
    .roll_angle      (roll_angle),
    .accel_magnitude (accel_magnitude),
    .timestamp_ms    (timestamp_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .fall_phase      (fall_phase)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [MagW-1:0] tilt_mag(input logic signed [AngleW-1:0] a);
    int v;
    v = a;
    if (v < 0) v = -v;
    return MagW'(v);
  endfunction

  function automatic logic signed [AngleW-1:0] signed_tilt(input int unsigned mag);
    if ($urandom_range(1, 0) == 1) return AngleW'(-int'(mag));
    return AngleW'(mag);
  endfunction

  function automatic void fall_next(input fdf_phase_t ph, input logic [31:0] mark,
                                    input sample_t s, output fdf_phase_t nph,
                                    output logic [31:0] nmark);
    logic [MagW-1:0] pm;
    logic [MagW-1:0] rm;
    logic [31:0]     gone;
    pm    = tilt_mag(s.pitch);
    rm    = tilt_mag(s.roll);
    gone  = s.ts - mark;
    nph   = ph;
    nmark = mark;
    case (ph)
      PH_IDLE: begin
        if (s.accel > cfg_copy.shock_level) begin
          nph   = PH_IMPACT;
          nmark = s.ts;
        end
      end
      PH_IMPACT: begin
        if (gone > 32'(cfg_copy.stable_window_ms)) begin
          if (pm < MagW'(cfg_copy.lay_angle) || rm < MagW'(cfg_copy.lay_angle)) begin
            nph   = PH_CONFIRMED;
            nmark = s.ts;
          end else begin
            nph = PH_IDLE;
          end
        end
      end
      PH_CONFIRMED: begin
        if (pm > MagW'(cfg_copy.stand_angle) || rm > MagW'(cfg_copy.stand_angle)) begin
          nph = PH_IDLE;
        end else if (s.accel > cfg_copy.movement_threshold) begin
          nph = PH_IDLE;
        end else if (gone > 32'(cfg_copy.critical_window_ms)) begin
          nph = PH_CRITICAL;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic sample_t posed(input int p, input int r, input int a,
                                    input logic [31:0] t);
    sample_t s;
    s.pitch = AngleW'(p);
    s.roll  = AngleW'(r);
    s.accel = AccelW'(a);
    s.ts    = t;
    s.fixed = 1'b0;
    s.want  = PH_IDLE;
    return s;
  endfunction

  // Shape each sample on the tracked phase so that episodes run through
  // impact, posture check and clearing; a tenth is unshaped noise.
  function automatic sample_t build_sample();
    sample_t     s;
    int unsigned pick;
    int unsigned span;
    s = posed(int'($urandom), int'($urandom), int'($urandom), now_ms + $urandom_range(200, 0));
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      s.ts = $urandom;
      return s;
    end
    case (track_phase)
      PH_IDLE: begin
        if (pick < 45 && cfg_copy.shock_level != 16'hFFFF)
          s.accel = AccelW'($urandom_range(65535, cfg_copy.shock_level + 1));
        else
          s.accel = AccelW'($urandom_range(cfg_copy.shock_level, 0));
      end
      PH_IMPACT: begin
        span = cfg_copy.stable_window_ms / 2 + 2;
        s.ts = now_ms + $urandom_range(span, 0);
        if (pick < 75 && cfg_copy.lay_angle != 0) begin
          if (pick[0]) s.pitch = signed_tilt($urandom_range(cfg_copy.lay_angle - 1, 0));
          else         s.roll  = signed_tilt($urandom_range(cfg_copy.lay_angle - 1, 0));
        end
      end
      PH_CONFIRMED: begin
        span = cfg_copy.critical_window_ms / 4 + 2;
        s.ts = now_ms + $urandom_range(span, 0);
        s.pitch = signed_tilt($urandom_range(cfg_copy.stand_angle, 0));
        s.roll  = signed_tilt($urandom_range(cfg_copy.stand_angle, 0));
        s.accel = AccelW'($urandom_range(cfg_copy.movement_threshold, 0));
        if (pick < 25) begin
          s.roll = signed_tilt($urandom_range(4096, cfg_copy.stand_angle + 1));
        end else if (pick < 40 && cfg_copy.movement_threshold != 16'hFFFF) begin
          s.accel = AccelW'($urandom_range(65535, cfg_copy.movement_threshold + 1));
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    fdf_phase_t  nph;
    logic [31:0] nmark;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    pitch_angle     <= s.pitch;
    roll_angle      <= s.roll;
    accel_magnitude <= s.accel;
    timestamp_ms    <= s.ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fall_next(track_phase, track_mark, s, nph, nmark);
    track_phase = nph;
    track_mark  = nmark;
    phase_due.push_back(s.fixed ? s.want : nph);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (phase_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_settings(input fdf_cfg_t v);
    logic [CfgIdxW-1:0]  idx [8];
    logic [CfgDataW-1:0] val [8];
    idx[0] = REG_SHOCK_LEVEL;        val[0] = v.shock_level;
    idx[1] = REG_STABLE_WINDOW_MS;   val[1] = v.stable_window_ms;
    idx[2] = RegSpareLo;             val[2] = CfgDataW'($urandom);
    idx[3] = REG_LAY_ANGLE;          val[3] = {4'($urandom), v.lay_angle};
    idx[4] = REG_CRITICAL_WINDOW_MS; val[4] = v.critical_window_ms;
    idx[5] = REG_STAND_ANGLE;        val[5] = {4'($urandom), v.stand_angle};
    idx[6] = RegSpareHi;             val[6] = CfgDataW'($urandom);
    idx[7] = REG_MOVEMENT_THRESHOLD; val[7] = v.movement_threshold;
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      case (idx[k])
        REG_SHOCK_LEVEL:        cfg_copy.shock_level        = val[k];
        REG_STABLE_WINDOW_MS:   cfg_copy.stable_window_ms   = val[k];
        REG_LAY_ANGLE:          cfg_copy.lay_angle          = val[k][LimitW-1:0];
        REG_CRITICAL_WINDOW_MS: cfg_copy.critical_window_ms = val[k];
        REG_STAND_ANGLE:        cfg_copy.stand_angle        = val[k][LimitW-1:0];
        REG_MOVEMENT_THRESHOLD: cfg_copy.movement_threshold = val[k];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (phase_due.size() == 0) begin
        note_mismatch($sformatf("fall_phase %0d with no sample pending", fall_phase));
      end else begin
        due_phase = phase_due.pop_front();
        if (fall_phase !== due_phase)
          note_mismatch($sformatf("fall_phase %0d, expected %0d", fall_phase, due_phase));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    sample_t     s;
    fdf_phase_t  guess_phase;
    logic [31:0] guess_mark;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_SHOCK_LEVEL;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    pitch_angle     <= '0;
    roll_angle      <= '0;
    accel_magnitude <= '0;
    timestamp_ms    <= '0;
    cfg_copy = '{ShockLevelRst, StableWindowRst, LayAngleRst,
                 CriticalWindowRst, StandAngleRst, MovementThresholdRst};
    track_phase   = PH_IDLE;
    track_mark    = '0;
    now_ms        = '0;
    send_idle_pct = 28;
    recv_idle_pct = 70;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i]) begin
      send_sample(probe_rows[i]);
      now_ms = probe_rows[i].ts;
    end

    for (int set_i = 0; set_i < 6; set_i++) begin
      settle();
      send_idle_pct = (set_i < 2) ? 28 : (set_i < 4) ? 70 : 0;
      recv_idle_pct = (set_i < 2) ? 70 : (set_i < 4) ? 28 : 0;
      load_settings(phase_settings[set_i]);
      repeat (SetItems) begin
        s = build_sample();
        fall_next(track_phase, track_mark, s, guess_phase, guess_mark);
        // hold off the sticky alarm: standing always clears a confirmed fall
        if (guess_phase == PH_CRITICAL && !allow_critical) s.pitch = AngleW'(-4096);
        now_ms = s.ts;
        send_sample(s);
      end
    end

    // drive one clean episode into the critical phase, then keep sampling
    allow_critical = 1'b1;
    s = posed(-4096, -4096, 0, now_ms + 32'd70000);
    send_sample(s);
    s = posed(0, 0, 65535, s.ts + 32'd1);
    send_sample(s);
    s = posed(0, 0, 0, s.ts + 32'd600);
    send_sample(s);
    s = posed(0, 0, 0, s.ts + 32'd2100);
    send_sample(s);
    now_ms = s.ts;
    repeat (12) begin
      s = build_sample();
      now_ms = s.ts;
      send_sample(s);
    end
    settle();

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
